// File: rtl/core/crsup_pkg.sv
`default_nettype none

package crsup_pkg;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [7:0] CNT_MAX              = 8'hFF;
	localparam logic [7:0] ESCALATE_MIN_ATTEMPTS = 8'd2;

	localparam logic FUNC_SETUP = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic [1:0] CTRL_STOPPED    = 2'd0;
	localparam logic [1:0] CTRL_RUNNING    = 2'd1;
	localparam logic [1:0] CTRL_BUS_OFF    = 2'd2;
	localparam logic [1:0] CTRL_RECOVERING = 2'd3;

	localparam logic [1:0] SOFT_NONE     = 2'd0;
	localparam logic [1:0] SOFT_RECOVER  = 2'd1;
	localparam logic [1:0] SOFT_RESTART  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HARD_DEBOUNCE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPTS_THRESH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_ERROR_THRESH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_GRACE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT      = 3'd5;

	// Fields listed from the highest bit down; now_ms sits in the lowest bits.
	typedef struct packed {
		logic [6:0]  pad;
		logic        frame_seen;
		logic [7:0]  rx_err_count;
		logic [7:0]  tx_err_count;
		logic [1:0]  ctrl_state;
		logic        status_ok;
		logic        alert_err_passive;
		logic        alert_bus_off;
		logic        alert_bus_error;
		logic        alert_bus_recovered;
		logic        alerts_ok;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] pad;
		logic       got_frames;
		logic [7:0] attempt_count;
		logic       idle_flag;
		logic       hard_reset;
		logic [1:0] soft_action;
	} out_item_t;

	typedef struct packed {
		logic [31:0] soft_holdoff_ms;
		logic [31:0] hard_holdoff_ms;
		logic [7:0]  attempts_threshold;
		logic [7:0]  err_run_limit;
		logic [31:0] grace_window_ms;
		logic [31:0] idle_timeout_ms;
	} cfg_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 8'd1;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/crsup_cfg_regs.sv
`default_nettype none

module crsup_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [crsup_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [crsup_pkg::CFG_DATA_W-1:0]  wr_data,
	output crsup_pkg::cfg_t                        cfg
);
	import crsup_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.soft_holdoff_ms    <= 32'd1000;
			cfg_q.hard_holdoff_ms    <= 32'd10000;
			cfg_q.attempts_threshold <= 8'd5;
			cfg_q.err_run_limit      <= 8'd10;
			cfg_q.grace_window_ms    <= 32'd30000;
			cfg_q.idle_timeout_ms    <= 32'd10000;
		end else if (wr_en) begin
			case (wr_index)
				REG_RECOVERY_DEBOUNCE: cfg_q.soft_holdoff_ms    <= wr_data;
				REG_HARD_DEBOUNCE:     cfg_q.hard_holdoff_ms    <= wr_data;
				REG_ATTEMPTS_THRESH:   cfg_q.attempts_threshold <= wr_data[7:0];
				REG_BUS_ERROR_THRESH:  cfg_q.err_run_limit      <= wr_data[7:0];
				REG_STARTUP_GRACE:     cfg_q.grace_window_ms    <= wr_data;
				REG_IDLE_TIMEOUT:      cfg_q.idle_timeout_ms    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/crsup_core.sv
`default_nettype none

module crsup_core #(
	parameter int TIME_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             func,
	input  crsup_pkg::in_item_t   item,
	input  crsup_pkg::cfg_t       cfg,
	output crsup_pkg::out_item_t  result
);
	import crsup_pkg::*;

	// Wide enough for both a time difference and a 32-bit duration register.
	localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic [TIME_BITS-1:0] start_q, last_rec_q, last_hard_q, last_rx_q;
	logic [TIME_BITS-1:0] start_d, last_rec_d, last_hard_d, last_rx_d;
	logic [7:0]           att_q, run_q, att_d, run_d, run_inc, att_inc;
	logic                 idle_q, idle_d;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] since_start, since_rx, since_hard, since_rec;
	logic                 grace, go_idle, hard_ok, soft_ok, maxed;
	logic                 recover, from_run, early;
	logic [1:0]           soft_act;
	logic                 hard, got;

	assign now_t       = TIME_BITS'(item.now_ms);
	assign since_start = now_t - start_q;
	assign since_rx    = now_t - last_rx_q;
	assign since_hard  = now_t - last_hard_q;
	assign since_rec   = now_t - last_rec_q;

	assign grace   = CW'(since_start) < CW'(cfg.grace_window_ms);
	assign go_idle = !idle_q && !grace && (CW'(since_rx) > CW'(cfg.idle_timeout_ms));
	assign hard_ok = CW'(since_hard) > CW'(cfg.hard_holdoff_ms);
	assign soft_ok = CW'(since_rec) > CW'(cfg.soft_holdoff_ms);
	assign maxed   = item.status_ok && hard_ok &&
	                 (item.tx_err_count == CNT_MAX || item.rx_err_count == CNT_MAX);

	always_comb begin
		start_d     = start_q;
		last_rec_d  = last_rec_q;
		last_hard_d = last_hard_q;
		last_rx_d   = last_rx_q;
		att_d       = att_q;
		run_d       = run_q;
		idle_d      = idle_q;
		run_inc     = 8'd0;
		att_inc     = 8'd0;
		recover     = 1'b0;
		from_run    = 1'b0;
		early       = 1'b0;
		soft_act    = SOFT_NONE;
		hard        = 1'b0;
		got         = 1'b0;

		if (func == FUNC_SETUP) begin
			start_d     = now_t;
			last_hard_d = now_t;
			last_rx_d   = now_t;
		end else begin
			if (go_idle) begin
				idle_d = 1'b1;
				att_d  = 8'd0;
				run_d  = 8'd0;
			end

			if (item.alerts_ok) begin
				if (idle_d) begin
					if (item.alert_bus_recovered) begin
						idle_d = 1'b0;
						att_d  = 8'd0;
						run_d  = 8'd0;
					end
				end else if (!grace) begin
					if (maxed) begin
						// A saturated error counter goes straight to a hard reset.
						hard        = 1'b1;
						att_d       = 8'd0;
						last_hard_d = now_t;
						last_rec_d  = now_t;
						early       = 1'b1;
					end else begin
						if (item.alert_bus_recovered) begin
							att_d = 8'd0;
							run_d = 8'd0;
						end
						if (item.alert_bus_error) begin
							run_inc = sat_inc(run_d);
							if (run_inc >= cfg.err_run_limit && soft_ok) begin
								recover  = 1'b1;
								from_run = 1'b1;
								run_d    = 8'd0;
							end else begin
								run_d = run_inc;
							end
						end else begin
							run_d = 8'd0;
						end
						if (item.alert_bus_off) begin
							recover  = 1'b1;
							from_run = 1'b0;
							run_d    = 8'd0;
						end else if (item.alert_err_passive) begin
							if (soft_ok) begin
								recover  = 1'b1;
								from_run = 1'b0;
							end
							run_d = 8'd0;
						end
						if (recover && item.status_ok) begin
							if (from_run && att_d >= ESCALATE_MIN_ATTEMPTS && hard_ok) begin
								hard        = 1'b1;
								att_d       = 8'd0;
								last_hard_d = now_t;
								last_rec_d  = now_t;
								early       = 1'b1;
							end else begin
								case (item.ctrl_state)
									CTRL_BUS_OFF: soft_act = SOFT_RECOVER;
									CTRL_STOPPED: soft_act = SOFT_RESTART;
									default:      soft_act = SOFT_NONE;
								endcase
								att_inc    = sat_inc(att_d);
								att_d      = att_inc;
								last_rec_d = now_t;
								if (att_inc >= cfg.attempts_threshold && hard_ok) begin
									hard        = 1'b1;
									att_d       = 8'd0;
									last_hard_d = now_t;
								end
							end
						end
					end
				end
			end

			if (item.frame_seen && !early) begin
				got       = 1'b1;
				last_rx_d = now_t;
				if (idle_d) begin
					idle_d = 1'b0;
					att_d  = 8'd0;
					run_d  = 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			last_rec_q  <= '0;
			last_hard_q <= '0;
			last_rx_q   <= '0;
			att_q       <= 8'd0;
			run_q       <= 8'd0;
			idle_q      <= 1'b0;
		end else if (advance) begin
			start_q     <= start_d;
			last_rec_q  <= last_rec_d;
			last_hard_q <= last_hard_d;
			last_rx_q   <= last_rx_d;
			att_q       <= att_d;
			run_q       <= run_d;
			idle_q      <= idle_d;
		end
	end

	always_comb begin
		result               = '0;
		result.soft_action   = soft_act;
		result.hard_reset    = hard;
		result.idle_flag     = idle_d;
		result.attempt_count = att_d;
		result.got_frames    = got;
	end

endmodule

`default_nettype wire

// File: rtl/core/can_bus_error_recovery_supervisor_unit.sv
// CAN bus error recovery supervisor. Each input beat is a setup event (tuser low) or a
// periodic tick (tuser high) and yields exactly one result beat. A beat is captured in
// an input register; the decision logic and the supervisor state update run on it once
// the output register can take a result, and the result lands in that output register.
// One beat per clock is sustained while m_tready stays high, set by the combinational
// decision path between the input and result registers; the output register lets a
// new beat enter while a result waits. The configuration port is always ready and its
// writes take effect on the next edge. Times are TIME_BITS wide and all differences
// wrap at that width.
`default_nettype none

module can_bus_error_recovery_supervisor_unit #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// now_ms[31:0], alerts_ok, alert_bus_recovered, alert_bus_error, alert_bus_off,
	// alert_err_passive, status_ok, ctrl_state[1:0], tx_err_count[7:0],
	// rx_err_count[7:0], frame_seen, zero fill
	input  wire logic [crsup_pkg::IN_DATA_W-1:0]   s_tdata,
	// func
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// soft_action[1:0], hard_reset, idle_flag, attempt_count[7:0], got_frames, zero fill
	output logic [crsup_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [crsup_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [crsup_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import crsup_pkg::*;

	in_item_t  item_s1;
	logic      func_s1;
	logic      valid_s1;
	out_item_t res_d;
	out_item_t res_q;
	logic      res_valid_q;
	logic      advance;
	cfg_t      cfg;

	assign advance   = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata);
			func_s1 <= s_tuser;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	crsup_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	crsup_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.func    (func_s1),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_q;

endmodule

`default_nettype wire

// File: rtl/core/crsup_checker.sv
`default_nettype none

module crsup_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic [crsup_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import crsup_pkg::*;

	out_item_t res;

	assign res = out_item_t'(m_tdata);

	// A held result beat must not change under backpressure.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Every hard reset clears the attempt count.
	a_hard_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.hard_reset |-> res.attempt_count == 8'd0)
		else $error("hard reset left a nonzero attempt count");

	// Recovery, and thus a hard reset, only happens while the bus is not idle.
	a_hard_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.hard_reset |-> !res.idle_flag)
		else $error("hard reset reported while idle");

	// A received frame always ends the idle condition.
	a_frame_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.got_frames |-> !res.idle_flag)
		else $error("idle reported on a beat with frames");

endmodule

bind can_bus_error_recovery_supervisor_unit crsup_checker u_checker (.*);

`default_nettype wire

// File: tb/recovery_decision_checker.sv
`default_nettype none

module recovery_decision_checker
	import crsup_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         awaiting,
	output int                         soft_seen,
	output int                         hard_seen,
	output int                         idle_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Supervisor copy: register settings and tracked state.
	cfg_t        regs;
	logic [31:0] start_ms;
	logic [31:0] last_soft_ms;
	logic [31:0] last_hard_ms;
	logic [31:0] last_frame_ms;
	logic [7:0]  attempt_cnt;
	logic [7:0]  err_streak;
	logic        link_quiet;

	out_item_t   pending_decisions[$];
	out_item_t   seen_item;
	out_item_t   want_item;
	int          results_checked;

	function automatic void note_hard_reset(input logic [31:0] t);
		attempt_cnt  = '0;
		last_hard_ms = t;
		last_soft_ms = t;
	endfunction

	function automatic out_item_t decide_recovery(input logic func, input in_item_t it);
		out_item_t   r;
		logic [31:0] now;
		logic        in_grace;
		logic        hard_ok;
		logic        soft_ok;
		logic        recover;
		logic        from_run;
		logic        done;
		r    = '0;
		now  = it.now_ms;
		done = 1'b0;
		if (func == FUNC_SETUP) begin
			start_ms      = now;
			last_hard_ms  = now;
			last_frame_ms = now;
		end else begin
			in_grace = (now - start_ms) < regs.grace_window_ms;
			if (!link_quiet && !in_grace && (now - last_frame_ms) > regs.idle_timeout_ms) begin
				link_quiet  = 1'b1;
				attempt_cnt = '0;
				err_streak  = '0;
			end
			if (it.alerts_ok) begin
				if (link_quiet) begin
					if (it.alert_bus_recovered) begin
						link_quiet  = 1'b0;
						attempt_cnt = '0;
						err_streak  = '0;
					end
				end else if (!in_grace) begin
					hard_ok  = (now - last_hard_ms) > regs.hard_holdoff_ms;
					soft_ok  = (now - last_soft_ms) > regs.soft_holdoff_ms;
					recover  = 1'b0;
					from_run = 1'b0;
					// A maxed error counter forces a reset and ends the tick.
					if (it.status_ok && hard_ok
							&& (it.tx_err_count == CNT_MAX || it.rx_err_count == CNT_MAX)) begin
						note_hard_reset(now);
						r.hard_reset = 1'b1;
						done = 1'b1;
					end else begin
						if (it.alert_bus_recovered) begin
							attempt_cnt = '0;
							err_streak  = '0;
						end
						if (it.alert_bus_error) begin
							err_streak = (err_streak == CNT_MAX) ? CNT_MAX : err_streak + 8'd1;
							if (err_streak >= regs.err_run_limit && soft_ok) begin
								recover    = 1'b1;
								from_run   = 1'b1;
								err_streak = '0;
							end
						end else begin
							err_streak = '0;
						end
						if (it.alert_bus_off) begin
							recover    = 1'b1;
							from_run   = 1'b0;
							err_streak = '0;
						end else if (it.alert_err_passive) begin
							if (soft_ok) begin
								recover  = 1'b1;
								from_run = 1'b0;
							end
							err_streak = '0;
						end
						if (recover && it.status_ok) begin
							if (from_run && attempt_cnt >= ESCALATE_MIN_ATTEMPTS
									&& hard_ok) begin
								note_hard_reset(now);
								r.hard_reset = 1'b1;
								done = 1'b1;
							end else begin
								if (it.ctrl_state == CTRL_BUS_OFF)
									r.soft_action = SOFT_RECOVER;
								else if (it.ctrl_state == CTRL_STOPPED)
									r.soft_action = SOFT_RESTART;
								attempt_cnt  = (attempt_cnt == CNT_MAX) ? CNT_MAX
									: attempt_cnt + 8'd1;
								last_soft_ms = now;
								if (attempt_cnt >= regs.attempts_threshold && hard_ok) begin
									note_hard_reset(now);
									r.hard_reset = 1'b1;
								end
							end
						end
					end
				end
			end
			if (!done && it.frame_seen) begin
				r.got_frames  = 1'b1;
				last_frame_ms = now;
				if (link_quiet) begin
					link_quiet  = 1'b0;
					attempt_cnt = '0;
					err_streak  = '0;
				end
			end
		end
		r.idle_flag     = link_quiet;
		r.attempt_count = attempt_cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.soft_holdoff_ms    = 32'd1000;
			regs.hard_holdoff_ms    = 32'd10000;
			regs.attempts_threshold = 8'd5;
			regs.err_run_limit      = 8'd10;
			regs.grace_window_ms    = 32'd30000;
			regs.idle_timeout_ms    = 32'd10000;
			start_ms        = '0;
			last_soft_ms    = '0;
			last_hard_ms    = '0;
			last_frame_ms   = '0;
			attempt_cnt     = '0;
			err_streak      = '0;
			link_quiet      = 1'b0;
			pending_decisions.delete();
			results_checked = 0;
			mismatches      = 0;
			soft_seen       = 0;
			hard_seen       = 0;
			idle_seen       = 0;
			awaiting       <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RECOVERY_DEBOUNCE: regs.soft_holdoff_ms    = cfg_data;
					REG_HARD_DEBOUNCE:     regs.hard_holdoff_ms    = cfg_data;
					REG_ATTEMPTS_THRESH:   regs.attempts_threshold = cfg_data[7:0];
					REG_BUS_ERROR_THRESH:  regs.err_run_limit      = cfg_data[7:0];
					REG_STARTUP_GRACE:     regs.grace_window_ms    = cfg_data;
					REG_IDLE_TIMEOUT:      regs.idle_timeout_ms    = cfg_data;
					default: ;
				endcase
			end
			// Results are handled before new beats so a beat can never match
			// a prediction made at the same edge.
			if (m_tvalid && m_tready) begin
				seen_item = out_item_t'(m_tdata);
				results_checked++;
				if (pending_decisions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result %0d arrived with nothing outstanding: %h",
							$time, results_checked, m_tdata);
				end else begin
					want_item = pending_decisions.pop_front();
					if (seen_item.soft_action !== want_item.soft_action
							|| seen_item.hard_reset !== want_item.hard_reset
							|| seen_item.idle_flag !== want_item.idle_flag
							|| seen_item.attempt_count !== want_item.attempt_count
							|| seen_item.got_frames !== want_item.got_frames) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"[%0t] result %0d expected soft=%0d hard=%0d",
								" idle=%0d attempts=%0d frames=%0d"},
								$time, results_checked, want_item.soft_action,
								want_item.hard_reset, want_item.idle_flag,
								want_item.attempt_count, want_item.got_frames);
							$display({"             actual   soft=%0d hard=%0d",
								" idle=%0d attempts=%0d frames=%0d"},
								seen_item.soft_action, seen_item.hard_reset,
								seen_item.idle_flag, seen_item.attempt_count,
								seen_item.got_frames);
						end
					end
				end
				if (seen_item.soft_action != SOFT_NONE)
					soft_seen++;
				if (seen_item.hard_reset)
					hard_seen++;
				if (seen_item.idle_flag)
					idle_seen++;
			end
			if (s_tvalid && s_tready)
				pending_decisions.push_back(decide_recovery(s_tuser, in_item_t'(s_tdata)));
			awaiting <= pending_decisions.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/can_bus_error_recovery_supervisor_unit_tb.sv
`default_nettype none

module can_bus_error_recovery_supervisor_unit_tb;
	import crsup_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = FUNC_TICK;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int          mismatches;
	int          awaiting;
	int          soft_seen;
	int          hard_seen;
	int          idle_seen;
	int          items_sent = 0;
	int          settings_used = 1;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	logic        gaps_on = 1'b1;
	logic [31:0] clock_ms;

	always #4 clk = ~clk;

	can_bus_error_recovery_supervisor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	recovery_decision_checker decision_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.awaiting  (awaiting),
		.soft_seen (soft_seen),
		.hard_seen (hard_seen),
		.idle_seen (idle_seen)
	);

	// Result side back-pressure in bursts.
	always @(posedge clk) begin
		if (!gaps_on) begin
			stall_left = 0;
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, awaiting);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic in_item_t make_item(input logic [31:0] t, input logic ok, rec, berr,
			boff, epass, sok, input logic [1:0] st, input logic [7:0] tx, rx,
			input logic fr);
		in_item_t it;
		it = '0;
		it.now_ms              = t;
		it.alerts_ok           = ok;
		it.alert_bus_recovered = rec;
		it.alert_bus_error     = berr;
		it.alert_bus_off       = boff;
		it.alert_err_passive   = epass;
		it.status_ok           = sok;
		it.ctrl_state          = st;
		it.tx_err_count        = tx;
		it.rx_err_count        = rx;
		it.frame_seen          = fr;
		return it;
	endfunction

	// A bus-off rate of 100 makes a storm: every read succeeds and nothing clears the
	// attempt count, so each tick is a recovery.
	function automatic in_item_t random_tick(input logic [31:0] t, input int frame_pct,
			input int boff_pct);
		logic storm;
		storm = (boff_pct >= 100);
		return make_item(t,
			storm || $urandom_range(0, 99) < 92,
			!storm && $urandom_range(0, 99) < 10,
			$urandom_range(0, 99) < 50,
			$urandom_range(0, 99) < boff_pct,
			$urandom_range(0, 99) < 12,
			storm || $urandom_range(0, 99) < 90,
			2'($urandom_range(0, 3)),
			($urandom_range(0, 24) == 0) ? 8'hFF : 8'($urandom),
			($urandom_range(0, 24) == 0) ? 8'hFF : 8'($urandom),
			$urandom_range(0, 99) < frame_pct);
	endfunction

	task automatic send_item(input logic func, input in_item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= it;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(REG_RECOVERY_DEBOUNCE, c.soft_holdoff_ms);
		write_reg(REG_HARD_DEBOUNCE, c.hard_holdoff_ms);
		write_reg(REG_ATTEMPTS_THRESH, CFG_DATA_W'(c.attempts_threshold));
		write_reg(REG_BUS_ERROR_THRESH, CFG_DATA_W'(c.err_run_limit));
		write_reg(REG_STARTUP_GRACE, c.grace_window_ms);
		write_reg(REG_IDLE_TIMEOUT, c.idle_timeout_ms);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Waits until every outstanding result has come back, then adds slack before returning.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cfg_t set;
		int   n;
		int   frame_pct;
		int   boff_pct;
		int   r;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A short run on the values the block comes out of reset with.
		clock_ms = '0;
		send_item(FUNC_SETUP, random_tick(clock_ms, 60, 15));
		for (int i = 0; i < 12; i++) begin
			clock_ms += $urandom_range(1000, 6000);
			send_item(FUNC_TICK, random_tick(clock_ms, 60, 15));
		end
		settle();

		// Directed walk: grace, bus error escalation, threshold reset, maxed
		// counters, failed reads, idle entry and exit, and time wrap.
		load_settings('{32'd0, 32'd0, 8'd3, 8'd1, 32'd10, 32'd100});
		send_item(FUNC_SETUP, make_item(100, 1, 1, 1, 1, 1, 1, CTRL_RECOVERING, 8'hFF, 8'hFF, 1));
		send_item(FUNC_TICK, make_item(105, 1, 0, 0, 1, 0, 1, CTRL_BUS_OFF, 0, 0, 0));
		send_item(FUNC_TICK, make_item(120, 1, 0, 1, 0, 0, 1, CTRL_BUS_OFF, 0, 0, 1));
		send_item(FUNC_TICK, make_item(121, 1, 0, 1, 0, 0, 1, CTRL_STOPPED, 0, 0, 0));
		send_item(FUNC_TICK, make_item(122, 1, 0, 1, 0, 0, 1, CTRL_RUNNING, 0, 0, 1));
		send_item(FUNC_TICK, make_item(123, 1, 0, 0, 1, 0, 1, CTRL_RUNNING, 0, 0, 0));
		send_item(FUNC_TICK, make_item(124, 1, 0, 0, 0, 1, 1, CTRL_RECOVERING, 0, 0, 0));
		send_item(FUNC_TICK, make_item(125, 1, 0, 0, 1, 0, 1, CTRL_BUS_OFF, 0, 0, 0));
		send_item(FUNC_TICK, make_item(126, 1, 0, 0, 1, 0, 1, CTRL_BUS_OFF, 8'hFF, 0, 1));
		send_item(FUNC_TICK, make_item(127, 1, 0, 0, 1, 0, 0, CTRL_BUS_OFF, 0, 8'hFF, 0));
		send_item(FUNC_TICK, make_item(128, 0, 0, 0, 1, 0, 1, CTRL_STOPPED, 0, 0, 1));
		send_item(FUNC_TICK, make_item(129, 1, 1, 1, 0, 0, 1, CTRL_STOPPED, 0, 0, 0));
		send_item(FUNC_TICK, make_item(300, 1, 0, 0, 0, 0, 1, CTRL_RUNNING, 0, 0, 0));
		send_item(FUNC_TICK, make_item(301, 1, 0, 0, 1, 0, 1, CTRL_BUS_OFF, 0, 0, 0));
		send_item(FUNC_TICK, make_item(302, 1, 1, 0, 0, 0, 1, CTRL_RUNNING, 0, 0, 0));
		send_item(FUNC_TICK, make_item(500, 1, 0, 0, 0, 0, 1, CTRL_RUNNING, 0, 0, 1));
		send_item(FUNC_SETUP, make_item(32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, CTRL_STOPPED, 0, 0, 0));
		send_item(FUNC_TICK, make_item(32'hFFFF_FFFF, 1, 0, 0, 1, 0, 1, CTRL_BUS_OFF, 0, 0, 0));
		send_item(FUNC_TICK, make_item(32'h0000_0010, 1, 0, 0, 1, 0, 1, CTRL_STOPPED, 0, 0, 0));
		send_item(FUNC_TICK, make_item(32'h0000_0020, 1, 1, 1, 1, 1, 1, CTRL_RECOVERING,
			8'hFF, 8'hFF, 1));
		send_item(FUNC_TICK, make_item(32'h0000_0021, 0, 0, 0, 0, 0, 0, CTRL_STOPPED, 0, 0, 0));
		settle();

		for (int p = 0; p < 9; p++) begin
			set.soft_holdoff_ms    = $urandom_range(0, 40);
			set.hard_holdoff_ms    = $urandom_range(0, 150);
			set.attempts_threshold = 8'($urandom_range(1, 6));
			set.err_run_limit      = 8'($urandom_range(1, 5));
			set.grace_window_ms    = $urandom_range(0, 60);
			set.idle_timeout_ms    = $urandom_range(30, 400);
			boff_pct = 15;
			case (p)
				0: set = '{32'd0, 32'd0, 8'd1, 8'd1, 32'd0, 32'hFFFF_FFFF};
				2: set = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 32'hFFFF_FFFF,
					32'hFFFF_FFFF};
				4: begin
					// Long bus-off storm with no hard reset possible: attempts saturate.
					set = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 32'd0, 32'hFFFF_FFFF};
					boff_pct = 100;
				end
				5: begin
					set.attempts_threshold = 8'd0;
					set.err_run_limit      = 8'd0;
				end
				6: set = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd2, 8'd3, 32'd0, 32'd0};
				default: ;
			endcase
			gaps_on <= !(p == 3 || p == 8);
			load_settings(set);
			clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
				: $urandom;
			frame_pct = $urandom_range(10, 90);
			send_item(FUNC_SETUP, random_tick(clock_ms, frame_pct, boff_pct));
			n = (p == 4) ? 280 : 12;
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (r < 88)
					clock_ms += $urandom_range(0, 20);
				else if (r < 97)
					clock_ms += $urandom_range(0, 600);
				else
					clock_ms = $urandom;
				send_item(($urandom_range(0, 39) == 0) ? FUNC_SETUP : FUNC_TICK,
					random_tick(clock_ms, frame_pct, boff_pct));
			end
			settle();
		end

		$display("Ran %0d setup and tick beats under %0d register settings,",
			items_sent, settings_used);
		$display("thresholds 0 to 255, timers 0 to all ones; results held %0d soft actions,",
			soft_seen);
		$display("%0d hard resets, %0d idle.", hard_seen, idle_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
